// ----- rtl/vmt_pkg.sv -----
// ----------------------------------------------------------------------------
// vmt_pkg
// Widths and shared types for the vector3 move-towards pipeline.
// ----------------------------------------------------------------------------
package vmt_pkg;
  localparam int COORD_W = 32;
  localparam int STEP_W  = COORD_W - 1;
  localparam int MAG_W   = COORD_W + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int ROOT_W  = MAG_W;
  localparam int PROD_W  = MAG_W + STEP_W;
  localparam int Q_W     = MAG_W;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int DIV_STAGES  = Q_W;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] pos;
    logic [2:0][COORD_W-1:0] goal;
    logic [2:0]              neg;
    logic                    reached;
  } carry_t;
endpackage

// ----- rtl/vmt_div_lane.sv -----
// ----------------------------------------------------------------------------
// vmt_div_lane
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vmt_div_lane (
  input  logic                      clk,
  input  logic                      en,
  input  logic [vmt_pkg::PROD_W-1:0] num,
  input  logic [vmt_pkg::ROOT_W-1:0] den,
  output logic [vmt_pkg::Q_W-1:0]    quo
);
  import vmt_pkg::*;

  logic [PROD_W-1:0] n_s [0:DIV_STAGES];
  logic [ROOT_W-1:0] d_s [0:DIV_STAGES];
  logic [ROOT_W-1:0] r_s [0:DIV_STAGES];
  logic [Q_W-1:0]    q_s [0:DIV_STAGES];

  assign n_s[0] = num;
  assign d_s[0] = den;
  assign r_s[0] = ROOT_W'(num[PROD_W-1:Q_W]);
  assign q_s[0] = '0;

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_st
    logic [ROOT_W:0] trial;
    logic [ROOT_W:0] diff;
    assign trial = {r_s[j], n_s[j][Q_W-1-j]};
    assign diff  = trial - {1'b0, d_s[j]};
    always_ff @(posedge clk) begin
      if (en) begin
        n_s[j+1] <= n_s[j];
        d_s[j+1] <= d_s[j];
        if (trial >= {1'b0, d_s[j]}) begin
          r_s[j+1] <= diff[ROOT_W-1:0];
          q_s[j+1] <= {q_s[j][Q_W-2:0], 1'b1};
        end else begin
          r_s[j+1] <= trial[ROOT_W-1:0];
          q_s[j+1] <= {q_s[j][Q_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = q_s[DIV_STAGES];
endmodule

// ----- rtl/vector3_move_towards_unit.sv -----
// ----------------------------------------------------------------------------
// vector3_move_towards_unit
// Moves a Q16.16 point toward a goal by at most a step length.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_ready    pos_x..z, goal_x..z, step_len
//  out      out_valid/out_ready  new_x..z, reached
//
// One item per cycle while the output is not stalled, through 3 setup stages,
// 33 square-root stages (one root bit each), 33 divide stages (one quotient
// bit each) and the output register. Reset clears the valid bits only. A
// stall at the output freezes every stage; nothing is dropped or repeated.
module vector3_move_towards_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [vmt_pkg::COORD_W-1:0] pos_x,
  input  logic signed [vmt_pkg::COORD_W-1:0] pos_y,
  input  logic signed [vmt_pkg::COORD_W-1:0] pos_z,
  input  logic signed [vmt_pkg::COORD_W-1:0] goal_x,
  input  logic signed [vmt_pkg::COORD_W-1:0] goal_y,
  input  logic signed [vmt_pkg::COORD_W-1:0] goal_z,
  input  logic [vmt_pkg::STEP_W-1:0]  step_len,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [vmt_pkg::COORD_W-1:0] new_x,
  output logic signed [vmt_pkg::COORD_W-1:0] new_y,
  output logic signed [vmt_pkg::COORD_W-1:0] new_z,
  output logic                        reached
);
  import vmt_pkg::*;

  localparam int NV = 3 + SQRT_STAGES + DIV_STAGES;

  logic en;
  logic [NV:0] v;
  carry_t c1, c2, c3;
  logic [2:0][MAG_W-1:0]  mag1;
  logic [STEP_W-1:0]      step1;
  logic [2:0][SQ_W-1:0]   sq2;
  logic [2*STEP_W-1:0]    ss2;
  logic [2:0][PROD_W-1:0] prod2, prod3;
  logic [SQ_W-1:0]        sum3;
  logic [2:0][COORD_W-1:0] pin, gin;
  logic [SQ_W-1:0] sum_c;

  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign v[0] = in_valid;
  assign pin = {pos_z, pos_y, pos_x};
  assign gin = {goal_z, goal_y, goal_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      v[NV:1] <= '0;
    end else if (en) begin
      v[NV:1] <= v[NV-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [MAG_W-1:0] d;
        d = MAG_W'(signed'(gin[i])) - MAG_W'(signed'(pin[i]));
        c1.neg[i] <= d[MAG_W-1];
        mag1[i]   <= d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
      end
      c1.pos     <= pin;
      c1.goal    <= gin;
      c1.reached <= 1'b0;
      step1      <= step_len;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq2[i]   <= SQ_W'(mag1[i]) * SQ_W'(mag1[i]);
        prod2[i] <= PROD_W'(mag1[i]) * PROD_W'(step1);
      end
      ss2 <= (2*STEP_W)'(step1) * (2*STEP_W)'(step1);
      c2  <= c1;
    end
  end

  assign sum_c = sq2[0] + sq2[1] + sq2[2];

  always_ff @(posedge clk) begin
    if (en) begin
      c3.pos     <= c2.pos;
      c3.goal    <= c2.goal;
      c3.neg     <= c2.neg;
      c3.reached <= (sum_c == '0) || (SQ_W'(ss2) >= sum_c);
      sum3       <= sum_c;
      prod3      <= prod2;
    end
  end

  logic [SQ_W-1:0]        rad [0:SQRT_STAGES];
  logic [ROOT_W+1:0]      rem [0:SQRT_STAGES];
  logic [ROOT_W-1:0]      root [0:SQRT_STAGES];
  logic [2:0][PROD_W-1:0] sp  [0:SQRT_STAGES];
  carry_t                 sc  [0:SQRT_STAGES];

  assign rad[0]  = sum3;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign sp[0]   = prod3;
  assign sc[0]   = c3;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    logic [ROOT_W+3:0] r2;
    logic [ROOT_W+3:0] t;
    logic [ROOT_W+3:0] diff;
    assign r2   = {rem[k], rad[k][SQ_W-1:SQ_W-2]};
    assign t    = {2'b00, root[k], 2'b01};
    assign diff = r2 - t;
    always_ff @(posedge clk) begin
      if (en) begin
        rad[k+1] <= {rad[k][SQ_W-3:0], 2'b00};
        sp[k+1]  <= sp[k];
        sc[k+1]  <= sc[k];
        if (r2 >= t) begin
          rem[k+1]  <= diff[ROOT_W+1:0];
          root[k+1] <= {root[k][ROOT_W-2:0], 1'b1};
        end else begin
          rem[k+1]  <= r2[ROOT_W+1:0];
          root[k+1] <= {root[k][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  carry_t dc [0:DIV_STAGES];
  logic [2:0][Q_W-1:0] q;

  assign dc[0] = sc[SQRT_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_dc
    always_ff @(posedge clk) begin
      if (en) begin
        dc[j+1] <= dc[j];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vmt_div_lane u_div (
      .clk (clk),
      .en  (en),
      .num (sp[SQRT_STAGES][i]),
      .den (root[SQRT_STAGES]),
      .quo (q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[NV];
    end
  end

  always_ff @(posedge clk) begin
    logic [2:0][COORD_W-1:0] r;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dc[DIV_STAGES].reached) begin
          r[i] = dc[DIV_STAGES].goal[i];
        end else if (dc[DIV_STAGES].neg[i]) begin
          r[i] = dc[DIV_STAGES].pos[i] - q[i][COORD_W-1:0];
        end else begin
          r[i] = dc[DIV_STAGES].pos[i] + q[i][COORD_W-1:0];
        end
      end
      new_x   <= r[0];
      new_y   <= r[1];
      new_z   <= r[2];
      reached <= dc[DIV_STAGES].reached;
    end
  end
endmodule

// ----- rtl/vmt_checker.sv -----
// ----------------------------------------------------------------------------
// vmt_checker
// Port-level checks for the move-towards unit, bound to the top level.
// ----------------------------------------------------------------------------
module vmt_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] new_x,
  input logic reached
);
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped before transfer");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(new_x) && $stable(reached))
    else $error("output payload changed while stalled");
endmodule

bind vector3_move_towards_unit vmt_checker u_vmt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .new_x     (new_x),
  .reached   (reached)
);
